/* rtl/dkes_pkg.sv */
`default_nettype none

package dkes_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned TAG_W   = 7;

  typedef struct packed {
    logic [YEAR_W-1:0]  birth_year;
    logic [MONTH_W-1:0] birth_month;
    logic [DAY_W-1:0]   birth_day;
    logic               last_entry;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   entry_tag;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic               last_result;
  } out_item_t;

  // one stored entry: date first so the packed value orders by date
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WB,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_HOLD
  } state_e;

  typedef enum logic [1:0] {
    RD_I,
    RD_J_FIRST,
    RD_J_NEXT,
    RD_K
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_LOAD,
    WR_J,
    WR_I
  } wr_sel_e;

  typedef struct packed {
    logic    cnt_inc;
    logic    cnt_clr;
    logic    idx_clr;
    logic    i_inc;
    logic    j_first;
    logic    j_next;
    logic    k_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cur_ld;
    logic    out_ld;
    logic    out_take;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic one_entry;
    logic last_i;
    logic last_j;
    logic last_k;
    logic swap;
  } ctrl_status_t;

endpackage

`default_nettype wire

/* rtl/dkes_ram.sv */
`default_nettype none

module dkes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/dkes_ctrl.sv */
`default_nettype none

module dkes_ctrl
  import dkes_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_last_i,
  output logic              in_stall_o,
  input  wire logic         out_stall_i,
  input  wire ctrl_status_t status_i,
  output ctrl_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_stall_o      = 1'b1;
    cmd_o.cnt_inc   = 1'b0;
    cmd_o.cnt_clr   = 1'b0;
    cmd_o.idx_clr   = 1'b0;
    cmd_o.i_inc     = 1'b0;
    cmd_o.j_first   = 1'b0;
    cmd_o.j_next    = 1'b0;
    cmd_o.k_inc     = 1'b0;
    cmd_o.rd_en     = 1'b0;
    cmd_o.rd_sel    = RD_I;
    cmd_o.wr_en     = 1'b0;
    cmd_o.wr_sel    = WR_LOAD;
    cmd_o.cur_ld    = 1'b0;
    cmd_o.out_ld    = 1'b0;
    cmd_o.out_take  = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          // a full store drops the item but a last mark still counts
          cmd_o.cnt_inc = !status_i.full;
          cmd_o.wr_en   = !status_i.full;
          cmd_o.wr_sel  = WR_LOAD;
          if (in_last_i) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_START;
          end
        end
      end
      ST_START: begin
        state_d = status_i.one_entry ? ST_EM_RD : ST_RD_I;
      end
      ST_RD_I: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_I;
        state_d      = ST_LD_I;
      end
      ST_LD_I: begin
        cmd_o.cur_ld  = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_J_FIRST;
        cmd_o.j_first = 1'b1;
        state_d       = ST_CMP;
      end
      ST_CMP: begin
        // held entry goes to slot j, slot j's entry becomes the held one
        if (status_i.swap) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_J;
          cmd_o.cur_ld = 1'b1;
        end
        if (status_i.last_j) begin
          state_d = ST_WB;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_J_NEXT;
          cmd_o.j_next = 1'b1;
        end
      end
      ST_WB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_I;
        if (status_i.last_i) begin
          state_d = ST_EM_RD;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_RD_I;
        end
      end
      ST_EM_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_K;
        state_d      = ST_EM_LD;
      end
      ST_EM_LD: begin
        cmd_o.out_ld = 1'b1;
        state_d      = ST_EM_HOLD;
      end
      ST_EM_HOLD: begin
        if (!out_stall_i) begin
          cmd_o.out_take = 1'b1;
          if (status_i.last_k) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = ST_LOAD;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dkes_dpath.sv */
`default_nettype none

module dkes_dpath
  import dkes_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64,
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire in_item_t     in_item_i,
  input  wire ctrl_cmd_t    cmd_i,
  output ctrl_status_t      status_o,
  output logic              out_valid_o,
  output out_item_t         out_item_o
);

  logic [CW-1:0] cnt_q, cnt_m1;
  logic [IW-1:0] i_q, j_q, k_q;
  entry_t        cur_q;
  out_item_t     out_q;
  logic          out_valid_q;

  logic [IW-1:0]      raddr, waddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  entry_t             rd_entry, new_entry;

  assign cnt_m1   = cnt_q - CW'(1);
  assign rd_entry = entry_t'(rdata);

  always_comb begin
    new_entry.year  = in_item_i.birth_year;
    new_entry.month = in_item_i.birth_month;
    new_entry.day   = in_item_i.birth_day;
    new_entry.tag   = TAG_W'({1'b0, cnt_q} + (CW + 1)'(1));
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_I:       raddr = i_q;
      RD_J_FIRST: raddr = IW'(i_q + IW'(1));
      RD_J_NEXT:  raddr = IW'(j_q + IW'(1));
      RD_K:       raddr = k_q;
      default:    raddr = k_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_LOAD: begin
        waddr = IW'(cnt_q);
        wdata = new_entry;
      end
      WR_J: begin
        waddr = j_q;
        wdata = cur_q;
      end
      WR_I: begin
        waddr = i_q;
        wdata = cur_q;
      end
      default: begin
        waddr = i_q;
        wdata = cur_q;
      end
    endcase
  end

  dkes_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.idx_clr) begin
        i_q <= '0;
        k_q <= '0;
      end else begin
        if (cmd_i.i_inc) begin
          i_q <= IW'(i_q + IW'(1));
        end
        if (cmd_i.k_inc) begin
          k_q <= IW'(k_q + IW'(1));
        end
      end
      if (cmd_i.j_first) begin
        j_q <= IW'(i_q + IW'(1));
      end else if (cmd_i.j_next) begin
        j_q <= IW'(j_q + IW'(1));
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_ld) begin
      cur_q <= rd_entry;
    end
    if (cmd_i.out_ld) begin
      out_q.entry_tag   <= rd_entry.tag;
      out_q.out_year    <= rd_entry.year;
      out_q.out_month   <= rd_entry.month;
      out_q.out_day     <= rd_entry.day;
      out_q.last_result <= status_o.last_k;
    end
  end

  always_comb begin
    status_o.full      = (cnt_q == CW'(MAX_ENTRIES));
    status_o.one_entry = (cnt_q == CW'(1));
    status_o.last_i    = (CW'(i_q) == CW'(cnt_m1 - CW'(1)));
    status_o.last_j    = (CW'(j_q) == cnt_m1);
    status_o.last_k    = (CW'(k_q) == cnt_m1);
    // packed date order is year, then month, then day
    status_o.swap      = {cur_q.year, cur_q.month, cur_q.day} >
                         {rd_entry.year, rd_entry.month, rd_entry.day};
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/date_key_exchange_sort_unit.sv */
// date exchange sort unit
// input channel (in_valid_i / in_stall_o / in_item_i): one date per item, taken
// one per cycle while loading. each stored item gets its arrival number as tag.
// items beyond MAX_ENTRIES are dropped; an item with last_entry set (stored or
// not) closes the set and starts the sort, input stays stalled until the
// whole sorted run has been delivered.
// sort: one held entry register against a single-read, single-write store.
// each outer pass loads slot i into the held register, compares it with every
// later slot (swapping when the held date is later) and writes it back to i.
// output channel (out_valid_o / out_stall_i / out_item_o): n items in sorted
// order from a registered output, last_result set on the final one. each item
// is read from the store, loaded into the register and handed off before the
// next is read; while the receiver stalls, the item holds and the unit waits.
// reset (rst_ni low, asynchronous) empties the store and returns to loading;
// the store contents themselves are not cleared.
`default_nettype none

module date_key_exchange_sort_unit
  import dkes_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  dkes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last_entry),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dkes_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
